// ===== rtl/core/heap_sort_macros.svh =====
// assertion macros shared by the heap sort rtl
`ifndef HEAP_SORT_MACROS_SVH
`define HEAP_SORT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define HS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hs_pkg.sv =====
// shared types and constants of the heap sort block
package hs_pkg;

  localparam int unsigned HS_CAPACITY    = 64;
  localparam int unsigned HS_VALUE_WIDTH = 32;
  localparam int unsigned FIELD_W        = 32;

  // update of the loop index register
  typedef enum logic [2:0] {
    K_KEEP,
    K_HALF,
    K_LAST,
    K_ZERO,
    K_DEC,
    K_INC
  } k_op_e;

  // store read address selection
  typedef enum logic [1:0] {
    RD_NODE,
    RD_CHILD,
    RD_ROOT
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    k_op_e   k_op;
    rd_sel_e rd_sel;
    logic    bld_init;
    logic    srt_init;
    logic    sift_leaf;
    logic    sift_step;
    logic    emit_ld;
    logic    clr;
  } hs_cmd_t;

  typedef struct packed {
    logic lc_in;
    logic descend;
    logic k_zero;
    logic k_one;
    logic cnt_lt2;
    logic out_valid;
    logic out_beat;
    logic out_end;
  } hs_sts_t;

endpackage

// ===== rtl/core/hs_if.sv =====
// valid/ready channels of the heap sort block
interface hs_in_if import hs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface hs_out_if import hs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] sorted_value;
  logic                      end_of_set;
  logic                      overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                output ready);
endinterface

// ===== rtl/core/heap_sort.sv =====
// top level of the heap sort block
// Takes signed values one beat at a time into a store of CAPACITY entries until a beat
// with last set, then heap-sorts the set in place and returns it in ascending order,
// end_of_set on the largest value and overflow on every result if beats beyond capacity
// were dropped. No input is taken from the last beat until the final result is taken.
// Time is set by the single store with two read ports and one write port: each sift level
// reads both children, then compares and writes; each sift is set up by a read and a load
// state, and each result passes a read, a load and a wait state that holds on output stall.
module heap_sort import hs_pkg::*; #(
  parameter int unsigned CAPACITY    = HS_CAPACITY,
  parameter int unsigned VALUE_WIDTH = HS_VALUE_WIDTH
) (
  input logic     clk_i,
  input logic     rst_ni,
  hs_in_if.sink   in_i,
  hs_out_if.source out_o
);

  hs_cmd_t cmd;
  hs_sts_t sts;
  logic    in_ready;

  assign in_i.ready = in_ready;

  hs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hs_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (in_i.value),
    .sorted_value_o (out_o.sorted_value),
    .end_of_set_o   (out_o.end_of_set),
    .overflow_o     (out_o.overflow),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready)
  );

endmodule

// ===== rtl/core/hs_datapath.sv =====
// heap store, sift datapath, loop counters and output register
`include "heap_sort_macros.svh"

module hs_datapath import hs_pkg::*; #(
  parameter int unsigned CAPACITY    = HS_CAPACITY,
  parameter int unsigned VALUE_WIDTH = HS_VALUE_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hs_cmd_t                   cmd_i,
  output hs_sts_t                   sts_o,
  input  logic signed [FIELD_W-1:0] value_i,
  output logic signed [FIELD_W-1:0] sorted_value_o,
  output logic                      end_of_set_o,
  output logic                      overflow_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 1;

  logic [VALUE_WIDTH-1:0] mem_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd0_q, rd1_q, v_q;
  logic [CW-1:0]          count_q, k_q, size_q;
  logic [AW-1:0]          i_q;
  logic                   dropped_q;
  logic                   out_valid_q, out_end_q, out_ovf_q;
  logic [FIELD_W-1:0]     out_val_q;

  logic [AW-1:0]          ra0, ra1, wa;
  logic [VALUE_WIDTH-1:0] wd, in_fit, big_val;
  logic                   we, full;
  logic [XW-1:0]          lc, rc, big_idx;
  logic                   lc_in, rc_in, pick_r, descend;
  logic                   g_rl, g_lv, g_rv;
  logic signed [VALUE_WIDTH-1:0] s_l, s_r, s_v;

  assign full   = (count_q == CW'(CAPACITY));
  assign in_fit = VALUE_WIDTH'($unsigned(value_i));

  assign lc    = XW'({i_q, 1'b1});
  assign rc    = lc + XW'(1);
  assign lc_in = lc < XW'(size_q);
  assign rc_in = rc < XW'(size_q);

  // three compares side by side, then pick
  assign s_l     = rd0_q;
  assign s_r     = rd1_q;
  assign s_v     = v_q;
  assign g_rl    = s_r > s_l;
  assign g_lv    = s_l > s_v;
  assign g_rv    = s_r > s_v;
  assign pick_r  = rc_in && g_rl;
  assign big_val = pick_r ? rd1_q : rd0_q;
  assign big_idx = pick_r ? rc : lc;
  assign descend = pick_r ? g_rv : g_lv;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NODE: begin
        ra0 = k_q[AW-1:0];
        ra1 = k_q[AW-1:0];
      end
      RD_CHILD: begin
        ra0 = lc[AW-1:0];
        ra1 = rc[AW-1:0];
      end
      RD_ROOT: begin
        ra0 = '0;
        ra1 = k_q[AW-1:0];
      end
      default: begin
        ra0 = '0;
        ra1 = '0;
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = i_q;
    wd = v_q;
    if (cmd_i.load) begin
      we = !full;
      wa = count_q[AW-1:0];
      wd = in_fit;
    end else if (cmd_i.srt_init) begin
      we = 1'b1;
      wa = k_q[AW-1:0];
      wd = rd0_q;
    end else if (cmd_i.sift_leaf) begin
      we = 1'b1;
    end else if (cmd_i.sift_step) begin
      we = 1'b1;
      wd = descend ? big_val : v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd0_q <= mem_q[ra0];
    rd1_q <= mem_q[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.k_op)
      K_KEEP: k_q <= k_q;
      K_HALF: k_q <= count_q >> 1;
      K_LAST: k_q <= count_q - CW'(1);
      K_ZERO: k_q <= '0;
      K_DEC:  k_q <= k_q - CW'(1);
      K_INC:  k_q <= k_q + CW'(1);
      default: k_q <= k_q;
    endcase
    if (cmd_i.bld_init) begin
      v_q    <= rd0_q;
      i_q    <= k_q[AW-1:0];
      size_q <= count_q;
    end else if (cmd_i.srt_init) begin
      v_q    <= rd1_q;
      i_q    <= '0;
      size_q <= k_q;
    end else if (cmd_i.sift_step && descend) begin
      i_q <= big_idx[AW-1:0];
    end
    if (cmd_i.emit_ld) begin
      out_val_q <= FIELD_W'(s_l);
      out_end_q <= (k_q == count_q - CW'(1));
      out_ovf_q <= dropped_q;
    end
  end

  assign sorted_value_o = out_val_q;
  assign end_of_set_o   = out_end_q;
  assign overflow_o     = out_ovf_q;
  assign out_valid_o    = out_valid_q;

  assign sts_o.lc_in     = lc_in;
  assign sts_o.descend   = descend;
  assign sts_o.k_zero    = (k_q == '0);
  assign sts_o.k_one     = (k_q == CW'(1));
  assign sts_o.cnt_lt2   = (count_q < CW'(2));
  assign sts_o.out_valid = out_valid_q;
  assign sts_o.out_beat  = out_valid_q && out_ready_i;
  assign sts_o.out_end   = out_end_q;

  `HS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "store count above capacity")
  `HS_ASSERT_IMP(a_sift_in_heap, cmd_i.sift_step, CW'(i_q) < size_q, "sift node outside heap")
  `HS_ASSERT_NXT(a_sift_descends, cmd_i.sift_step && descend, i_q > $past(i_q),
                 "sift did not move toward the leaves")

endmodule

// ===== rtl/core/hs_ctrl.sv =====
// sequencer for load, heap build, sort-down and emission
`include "heap_sort_macros.svh"

module hs_ctrl import hs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  hs_sts_t sts_i,
  output hs_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_LOAD      = 11'b000_0000_0001,
    S_START     = 11'b000_0000_0010,
    S_BLD_RD    = 11'b000_0000_0100,
    S_BLD_LD    = 11'b000_0000_1000,
    S_SIFT_RD   = 11'b000_0001_0000,
    S_SIFT_CMP  = 11'b000_0010_0000,
    S_SRT_RD    = 11'b000_0100_0000,
    S_SRT_SW    = 11'b000_1000_0000,
    S_EMIT_RD   = 11'b001_0000_0000,
    S_EMIT_LD   = 11'b010_0000_0000,
    S_EMIT_WAIT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;  // 0 while building the heap, 1 while sorting down
  logic   sift_done;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    sift_done  = 1'b0;
    cmd_o      = '0;
    cmd_o.k_op   = K_KEEP;
    cmd_o.rd_sel = RD_NODE;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (sts_i.cnt_lt2) begin
          cmd_o.k_op = K_ZERO;
          state_d    = S_EMIT_RD;
        end else begin
          cmd_o.k_op = K_HALF;
          phase_d    = 1'b0;
          state_d    = S_BLD_RD;
        end
      end
      S_BLD_RD: begin
        cmd_o.rd_sel = RD_NODE;
        state_d      = S_BLD_LD;
      end
      S_BLD_LD: begin
        cmd_o.bld_init = 1'b1;
        state_d        = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        cmd_o.rd_sel = RD_CHILD;
        if (sts_i.lc_in) begin
          state_d = S_SIFT_CMP;
        end else begin
          cmd_o.sift_leaf = 1'b1;
          sift_done       = 1'b1;
        end
      end
      S_SIFT_CMP: begin
        cmd_o.sift_step = 1'b1;
        if (sts_i.descend) begin
          state_d = S_SIFT_RD;
        end else begin
          sift_done = 1'b1;
        end
      end
      S_SRT_RD: begin
        cmd_o.rd_sel = RD_ROOT;
        state_d      = S_SRT_SW;
      end
      S_SRT_SW: begin
        cmd_o.srt_init = 1'b1;
        state_d        = S_SIFT_RD;
      end
      S_EMIT_RD: begin
        cmd_o.rd_sel = RD_NODE;
        state_d      = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        cmd_o.k_op    = K_INC;
        state_d       = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (sts_i.out_beat) begin
          if (sts_i.out_end) begin
            cmd_o.clr = 1'b1;
            state_d   = S_LOAD;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // next node of the build loop or next slot of the sort-down loop, or on to the next phase
    if (sift_done) begin
      if (!phase_q) begin
        if (sts_i.k_zero) begin
          cmd_o.k_op = K_LAST;
          phase_d    = 1'b1;
          state_d    = S_SRT_RD;
        end else begin
          cmd_o.k_op = K_DEC;
          state_d    = S_BLD_RD;
        end
      end else begin
        if (sts_i.k_one) begin
          cmd_o.k_op = K_ZERO;
          state_d    = S_EMIT_RD;
        end else begin
          cmd_o.k_op = K_DEC;
          state_d    = S_SRT_RD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  `HS_ASSERT_IMP(a_no_load_while_emit, in_ready_o, !sts_i.out_valid,
                 "input taken while a result is pending")
  `HS_ASSERT_NXT(a_last_beat_to_load, sts_i.out_beat && sts_i.out_end, state_q == S_LOAD,
                 "final beat did not return to load")
  `HS_ASSERT_IMP(a_sort_slot_nonzero, state_q == S_SRT_RD, !sts_i.k_zero,
                 "sort-down reached slot zero")

endmodule

// ===== test/tb_heap_sort.sv =====
// testbench for the heap sort block: streams value sets and checks the ascending results
`timescale 1ns / 100ps

module tb_heap_sort import hs_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned RANDOM_ITEMS = 345;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [HS_VALUE_WIDTH-1:0] stored_t;

  typedef struct {
    field_t value;
    logic   last;
    bit     hold;   // wait until every sorted result is back before sending
    bit     quiet;  // no idling around this beat
  } send_item_t;

  typedef struct {
    field_t sorted_value;
    logic   end_of_set;
    logic   overflow;
  } sorted_item_t;

  logic clk_i;
  logic rst_ni;

  hs_in_if  in_if ();
  hs_out_if out_if ();

  heap_sort uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  send_item_t   send_q[$];
  sorted_item_t due_results[$];

  // mirror of the block state
  stored_t     mirror_store[HS_CAPACITY];
  int unsigned mirror_count;
  bit          mirror_dropped;

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned src_gap;
  int unsigned sink_gap;
  bit          in_taken;
  bit          out_taken;
  bit          quiet_mode;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic sift_mirror(input int unsigned size, input int unsigned start);
    int unsigned node;
    int unsigned top;
    stored_t     t;
    node = start;
    forever begin
      top = node;
      if (2 * node + 1 < size && mirror_store[2 * node + 1] > mirror_store[top])
        top = 2 * node + 1;
      if (2 * node + 2 < size && mirror_store[2 * node + 2] > mirror_store[top])
        top = 2 * node + 2;
      if (top == node) return;
      t = mirror_store[node];
      mirror_store[node] = mirror_store[top];
      mirror_store[top] = t;
      node = top;
    end
  endtask

  // store one accepted beat; on last, sort and queue the whole set
  task automatic absorb_value(input field_t value, input logic last);
    int unsigned  n;
    stored_t      t;
    sorted_item_t res;
    if (mirror_count < HS_CAPACITY) begin
      mirror_store[mirror_count] = value[HS_VALUE_WIDTH-1:0];
      mirror_count++;
    end else begin
      mirror_dropped = 1'b1;
    end
    if (!last) return;
    n = mirror_count;
    if (n >= 2) begin
      for (int k = n / 2 + 1; k > 0; k--) sift_mirror(n, k - 1);
      for (int k = n - 1; k >= 1; k--) begin
        t = mirror_store[0];
        mirror_store[0] = mirror_store[k];
        mirror_store[k] = t;
        sift_mirror(k, 0);
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      res.sorted_value = mirror_store[k];  // sign extends to the port width
      res.end_of_set = (k + 1 == n);
      res.overflow = mirror_dropped;
      due_results.push_back(res);
    end
    mirror_count = 0;
    mirror_dropped = 1'b0;
  endtask

  task automatic queue_value(input field_t value, input logic last, input bit hold,
                             input bit quiet);
    send_item_t it;
    it.value = value;
    it.last = last;
    it.hold = hold;
    it.quiet = quiet;
    send_q.push_back(it);
  endtask

  function automatic field_t pick_value(input int unsigned style);
    int unsigned s;
    s = (style == 3) ? $urandom_range(0, 2) : style;
    case (s)
      0: return field_t'($urandom);
      1: return field_t'(int'($urandom_range(0, 15)) - 8);
      default: begin
        case ($urandom_range(0, 5))
          0: return {1'b1, {(FIELD_W-1){1'b0}}};
          1: return {1'b0, {(FIELD_W-1){1'b1}}};
          2: return '0;
          3: return '1;
          4: return {1'b1, {(FIELD_W-2){1'b0}}, 1'b1};
          default: return {1'b0, {(FIELD_W-2){1'b1}}, 1'b0};
        endcase
      end
    endcase
  endfunction

  task automatic queue_random_set(input int unsigned n, input bit hold);
    int unsigned style;
    bit          quiet;
    style = $urandom_range(0, 3);
    quiet = ($urandom_range(0, 4) == 0);
    for (int unsigned k = 0; k < n; k++)
      queue_value(pick_value(style), k + 1 == n, hold && k == 0, quiet);
  endtask

  // stimulus
  initial begin
    field_t      vmin;
    field_t      vmax;
    int unsigned total;
    int unsigned n;
    int unsigned r;
    int unsigned full_sets;
    int unsigned over_sets;
    vmin = {1'b1, {(FIELD_W-1){1'b0}}};
    vmax = {1'b0, {(FIELD_W-1){1'b1}}};

    // single element sets at both extremes
    queue_value(vmax, 1'b1, 1'b0, 1'b0);
    queue_value(vmin, 1'b1, 1'b0, 1'b0);
    // pairs in both orders
    queue_value(vmax, 1'b0, 1'b0, 1'b0);
    queue_value(vmin, 1'b1, 1'b0, 1'b0);
    queue_value(vmin, 1'b0, 1'b1, 1'b0);
    queue_value(vmax, 1'b1, 1'b0, 1'b0);
    // sign boundaries and duplicates
    queue_value('0, 1'b0, 1'b0, 1'b1);
    queue_value('1, 1'b0, 1'b0, 1'b1);
    queue_value(field_t'(1), 1'b0, 1'b0, 1'b1);
    queue_value(vmin, 1'b0, 1'b0, 1'b1);
    queue_value(vmax, 1'b0, 1'b0, 1'b1);
    queue_value('1, 1'b0, 1'b0, 1'b1);
    queue_value('0, 1'b1, 1'b0, 1'b1);
    // already ascending, then descending
    for (int k = 0; k < 5; k++) queue_value(field_t'(k * 3 - 6), k == 4, 1'b0, 1'b0);
    for (int k = 0; k < 5; k++) queue_value(field_t'(6 - k * 3), k == 4, 1'b0, 1'b0);

    // random sets, mostly small, a few full and a few overflowing
    total = 0;
    full_sets = 0;
    over_sets = 0;
    while (total < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (full_sets == 0 && total > 40) r = 90;
      if (over_sets == 0 && total > 150) r = 97;
      if (r >= 88 && r < 94 && full_sets < 3) begin
        n = HS_CAPACITY;
        full_sets++;
      end else if (r >= 94 && over_sets < 2) begin
        n = HS_CAPACITY + $urandom_range(1, 3);
        over_sets++;
      end else if (r < 70) begin
        n = $urandom_range(1, 10);
      end else begin
        n = $urandom_range(11, 30);
      end
      queue_random_set(n, $urandom_range(0, 3) == 0 || n > HS_CAPACITY);
      total += n;
    end
  end

  // reset and end of run
  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    src_gap = 0;
    sink_gap = 0;
    quiet_mode = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (send_q.size() != 0 || in_if.valid || due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // input driver
  always @(negedge clk_i) begin : src_drv
    send_item_t nxt;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (send_q.size() != 0 && !(send_q[0].hold && due_results.size() != 0)) begin
        nxt = send_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.value <= nxt.value;
        in_if.last <= nxt.last;
        quiet_mode <= nxt.quiet;
        src_gap <= nxt.quiet ? 0 : idle_len();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side ready driver
  always @(negedge clk_i) begin : sink_drv
    int unsigned g;
    if (rst_ni) begin
      if (out_taken && !quiet_mode) g = idle_len();
      else if (sink_gap > 0) g = sink_gap - 1;
      else if (!quiet_mode && $urandom_range(0, 15) == 0) g = idle_len();
      else g = 0;
      sink_gap <= g;
      out_if.ready <= (g == 0);
    end
  end

  // monitor: results are checked before a same-edge input beat is absorbed
  always @(posedge clk_i) begin : mon
    sorted_item_t exp_res;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d end %0b ovf %0b", out_if.sorted_value,
                     out_if.end_of_set, out_if.overflow);
        end else begin
          exp_res = due_results.pop_front();
          if (out_if.sorted_value !== exp_res.sorted_value ||
              out_if.end_of_set !== exp_res.end_of_set ||
              out_if.overflow !== exp_res.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp value %0d end %0b ovf %0b, got %0d %0b %0b",
                       exp_res.sorted_value, exp_res.end_of_set, exp_res.overflow,
                       out_if.sorted_value, out_if.end_of_set, out_if.overflow);
          end
        end
      end
      if (in_if.valid && in_if.ready) absorb_value(in_if.value, in_if.last);
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    mirror_count = 0;
    mirror_dropped = 1'b0;
  end

endmodule
